@@ hdl/dss_pkg.sv @@
// dss_pkg: shared types, codes and constants for the door servo sequencer.
// Used by dss_step and door_servo_sequencer_unit; depends on nothing.
package dss_pkg;

  // Servo end stops in degrees
  localparam logic [7:0]  ANGLE_OPEN  = 8'd170;
  localparam logic [7:0]  ANGLE_SHUT  = 8'd10;
  localparam logic [15:0] VISITOR_MAX = 16'hFFFF;

  // External door state codes (new_state / door_state)
  localparam logic [2:0] CODE_CLOSED    = 3'd0;
  localparam logic [2:0] CODE_OPENING   = 3'd1;
  localparam logic [2:0] CODE_WAITING   = 3'd2;
  localparam logic [2:0] CODE_CLOSING   = 3'd3;
  localparam logic [2:0] CODE_EMERGENCY = 3'd4;

  // Item kinds (in_tuser)
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_FORCE  = 2'd2;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_OPEN_DISTANCE = 2'd0;
  localparam logic [1:0] REG_STEP_INTERVAL = 2'd1;
  localparam logic [1:0] REG_HOLD_TIME     = 2'd2;

  // Reset values
  localparam logic [8:0]  OPEN_DISTANCE_RST = 9'd20;
  localparam logic [15:0] STEP_INTERVAL_RST = 16'd15;
  localparam logic [15:0] HOLD_TIME_RST     = 16'd3000;
  localparam logic [8:0]  HELD_DIST_RST     = 9'd10;

  typedef enum logic [4:0] {
    MODE_CLOSED    = 5'b00001,
    MODE_OPENING   = 5'b00010,
    MODE_WAITING   = 5'b00100,
    MODE_CLOSING   = 5'b01000,
    MODE_EMERGENCY = 5'b10000
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  angle;
    logic [15:0] visitors;
    logic [8:0]  held_dist;
    logic        first_open;
    logic        first_wait;
    logic [31:0] clock_ms;
    logic [31:0] last_step_ms;
    logic [31:0] wait_start_ms;
  } seq_state_t;

  typedef struct packed {
    logic [8:0]  open_distance;
    logic [15:0] step_interval;
    logic [15:0] hold_time;
  } seq_cfg_t;

  function automatic mode_t mode_from_code(input logic [2:0] code);
    mode_t m;
    unique case (code)
      CODE_CLOSED:    m = MODE_CLOSED;
      CODE_OPENING:   m = MODE_OPENING;
      CODE_WAITING:   m = MODE_WAITING;
      CODE_CLOSING:   m = MODE_CLOSING;
      CODE_EMERGENCY: m = MODE_EMERGENCY;
      default:        m = MODE_CLOSED;
    endcase
    return m;
  endfunction

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] c;
    unique case (m)
      MODE_CLOSED:    c = CODE_CLOSED;
      MODE_OPENING:   c = CODE_OPENING;
      MODE_WAITING:   c = CODE_WAITING;
      MODE_CLOSING:   c = CODE_CLOSING;
      MODE_EMERGENCY: c = CODE_EMERGENCY;
      default:        c = CODE_CLOSED;
    endcase
    return c;
  endfunction

endpackage

@@ hdl/dss_step.sv @@
// dss_step: next-state logic for one item (tick, distance sample, force state).
// Depends on dss_pkg.
module dss_step (
  input  dss_pkg::seq_state_t cur,
  input  dss_pkg::seq_cfg_t   cfg,
  input  logic [1:0]          kind,
  input  logic [8:0]          distance,
  input  logic [2:0]          new_state,
  output dss_pkg::seq_state_t nxt
);

  logic        may_open;
  logic [31:0] clk_inc;
  logic        step_due;

  assign may_open = (cur.mode != dss_pkg::MODE_WAITING) &&
                    (cur.mode != dss_pkg::MODE_EMERGENCY);
  assign clk_inc  = cur.clock_ms + 32'd1;
  assign step_due = (clk_inc - cur.last_step_ms) >= {16'd0, cfg.step_interval};

  always_comb begin
    nxt = cur;
    case (kind)
      dss_pkg::KIND_TICK: begin
        nxt.clock_ms = clk_inc;
        if (cur.held_dist <= cfg.open_distance && may_open) begin
          nxt.mode = dss_pkg::MODE_OPENING;
        end
        if (step_due) begin
          nxt.last_step_ms = clk_inc;
          unique case (nxt.mode)
            dss_pkg::MODE_OPENING: begin
              if (cur.first_open) begin
                if (cur.visitors != dss_pkg::VISITOR_MAX) begin
                  nxt.visitors = cur.visitors + 16'd1;
                end
                nxt.first_open = 1'b0;
              end
              if (cur.angle < dss_pkg::ANGLE_OPEN) begin
                nxt.angle = cur.angle + 8'd1;
              end else begin
                nxt.first_open = 1'b1;
                nxt.angle      = dss_pkg::ANGLE_OPEN;
                nxt.mode       = dss_pkg::MODE_WAITING;
              end
            end
            dss_pkg::MODE_WAITING: begin
              if (cur.first_wait) begin
                nxt.wait_start_ms = clk_inc;
                nxt.first_wait    = 1'b0;
              end
              if ((clk_inc - nxt.wait_start_ms) >= {16'd0, cfg.hold_time}) begin
                nxt.first_wait = 1'b1;
                nxt.mode       = dss_pkg::MODE_CLOSING;
              end
            end
            dss_pkg::MODE_CLOSING: begin
              if (cur.angle > dss_pkg::ANGLE_SHUT) begin
                nxt.angle = cur.angle - 8'd1;
              end else begin
                nxt.angle = dss_pkg::ANGLE_SHUT;
                nxt.mode  = dss_pkg::MODE_CLOSED;
              end
            end
            default: begin
              // closed and emergency: step does nothing
            end
          endcase
        end
      end
      dss_pkg::KIND_SAMPLE: begin
        nxt.held_dist = distance;
        if (distance <= cfg.open_distance && may_open) begin
          nxt.mode = dss_pkg::MODE_OPENING;
        end
      end
      dss_pkg::KIND_FORCE: begin
        if (new_state <= dss_pkg::CODE_EMERGENCY) begin
          nxt.mode       = dss_pkg::mode_from_code(new_state);
          nxt.first_open = 1'b1;
          nxt.first_wait = 1'b1;
        end
      end
      default: begin
        // unused kind: report status only
      end
    endcase
  end

endmodule

@@ hdl/door_servo_sequencer_unit.sv @@
// door_servo_sequencer_unit: top level of the automatic door sequencer.
// Depends on dss_pkg and dss_step.

// Automatic door sequencer. Each input transfer is one item: a millisecond
// tick (in_tuser 0), a distance sample (1) or a forced state (2); every item
// produces exactly one status transfer on the out_ channel with the door
// state, commanded servo angle, visitor count and servo-enable flag as they
// stand after the item. Ticks advance a 32-bit ms clock; every
// step_interval_ms the active state acts (opening ramps 1 deg/step to 170,
// waiting holds hold_time_ms, closing ramps down to 10). A held distance at
// or below open_distance forces opening unless waiting or in emergency.
// Throughput is one item per clock while out_tready keeps the output draining;
// out_tvalid rises once the item has passed the input register, then the
// state/result register updated through dss_step; a stall on out_tready
// holds it there. The item rate is set by the state update loop, which
// holds one 32-bit add plus two 32-bit subtract-and-compares.
// Registers (APB, 32-bit data): 0x0 open_distance[8:0], 0x4
// step_interval_ms[15:0], 0x8 hold_time_ms[15:0]; write only while idle.
module door_servo_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [8:0] distance, [11:9] new_state, [15:12] zero
  input  logic [1:0]  in_tuser,   // [1:0] kind
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [2:0] door_state, [10:3] servo_angle,
                                  // [26:11] visitor_count, [27] servo_on, [31:28] zero
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // ---------------- configuration registers ----------------
  dss_pkg::seq_cfg_t cfg_r;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_distance <= dss_pkg::OPEN_DISTANCE_RST;
      cfg_r.step_interval <= dss_pkg::STEP_INTERVAL_RST;
      cfg_r.hold_time     <= dss_pkg::HOLD_TIME_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        dss_pkg::REG_OPEN_DISTANCE: cfg_r.open_distance <= cfg_pwdata[8:0];
        dss_pkg::REG_STEP_INTERVAL: cfg_r.step_interval <= cfg_pwdata[15:0];
        dss_pkg::REG_HOLD_TIME:     cfg_r.hold_time     <= cfg_pwdata[15:0];
        default: begin
          // unmapped address: write dropped
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      dss_pkg::REG_OPEN_DISTANCE: cfg_prdata = {23'd0, cfg_r.open_distance};
      dss_pkg::REG_STEP_INTERVAL: cfg_prdata = {16'd0, cfg_r.step_interval};
      dss_pkg::REG_HOLD_TIME:     cfg_prdata = {16'd0, cfg_r.hold_time};
      default:                    cfg_prdata = 32'd0;
    endcase
  end

  // ---------------- handshake / pipeline control ----------------
  // Stage 1 captures the item; stage 2 (state + result register) advances
  // whenever the output register is empty or being drained.
  logic       in_valid_r;
  logic       in_valid_nxt;
  logic [1:0] kind_r;
  logic [8:0] dist_r;
  logic [2:0] nstate_r;
  logic       out_valid_r;
  logic       advance;
  logic       in_xfer;
  logic       do_step;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;
  assign do_step   = in_valid_r && advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r   <= in_tuser;
      dist_r   <= in_tdata[8:0];
      nstate_r <= in_tdata[11:9];
    end
  end

  // ---------------- sequencer state ----------------
  dss_pkg::seq_state_t st_r;
  dss_pkg::seq_state_t st_nxt;

  dss_step u_step (
    .cur       (st_r),
    .cfg       (cfg_r),
    .kind      (kind_r),
    .distance  (dist_r),
    .new_state (nstate_r),
    .nxt       (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode          <= dss_pkg::MODE_CLOSED;
      st_r.angle         <= dss_pkg::ANGLE_SHUT;
      st_r.visitors      <= 16'd0;
      st_r.held_dist     <= dss_pkg::HELD_DIST_RST;
      st_r.first_open    <= 1'b1;
      st_r.first_wait    <= 1'b1;
      st_r.clock_ms      <= 32'd0;
      st_r.last_step_ms  <= 32'd0;
      st_r.wait_start_ms <= 32'd0;
    end else if (do_step) begin
      st_r <= st_nxt;
    end
  end

  // ---------------- result register ----------------
  logic [31:0] out_data_r;
  logic        servo_on;

  assign servo_on = (st_nxt.mode == dss_pkg::MODE_OPENING) ||
                    (st_nxt.mode == dss_pkg::MODE_CLOSING);

  always_ff @(posedge clk) begin
    if (do_step) begin
      out_data_r <= {4'd0, servo_on, st_nxt.visitors, st_nxt.angle,
                     dss_pkg::mode_code(st_nxt.mode)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
